@@ src/skf_pkg.sv @@
// shared types, constants and the control program of the scalar kalman filter
// Q16.16 saturation helpers, datapath codes and the microcode table
// no dependencies
package skf_pkg;

    localparam int STEP_W = 5;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic [31:0] Q_ONE_OVF = 32'h8000_0000;

    // configuration register indexes
    localparam logic [2:0] REG_STATE_GAIN       = 3'd0;
    localparam logic [2:0] REG_PROCESS_NOISE    = 3'd1;
    localparam logic [2:0] REG_OBS_GAIN         = 3'd2;
    localparam logic [2:0] REG_MEAS_NOISE       = 3'd3;
    localparam logic [2:0] REG_INIT_ESTIMATE    = 3'd4;
    localparam logic [2:0] REG_INIT_COVARIANCE  = 3'd5;

    // register reset values (1.0, 0.0, 1.0, 4.0, 14.0, 6.0)
    localparam logic [31:0] RST_STATE_GAIN      = 32'h0001_0000;
    localparam logic [30:0] RST_PROCESS_NOISE   = 31'h0000_0000;
    localparam logic [31:0] RST_OBS_GAIN        = 32'h0001_0000;
    localparam logic [30:0] RST_MEAS_NOISE      = 31'h0004_0000;
    localparam logic [31:0] RST_INIT_ESTIMATE   = 32'h000E_0000;
    localparam logic [30:0] RST_INIT_COVARIANCE = 31'h0006_0000;

    // micro-operations
    localparam logic [3:0] OP_IDLE  = 4'd0;  // wait for an input transfer
    localparam logic [3:0] OP_MUL   = 4'd1;  // product register <= a * b
    localparam logic [3:0] OP_RND   = 4'd2;  // dst <= rounded, saturated product
    localparam logic [3:0] OP_ADDS  = 4'd3;  // dst <= sat(a + b)
    localparam logic [3:0] OP_SUBS  = 4'd4;  // dst <= sat(a - b)
    localparam logic [3:0] OP_ADDC  = 4'd5;  // dst <= clamp(a + b, 0, max)
    localparam logic [3:0] OP_SUBC  = 4'd6;  // dst <= clamp(a - b, 0, max)
    localparam logic [3:0] OP_DEN   = 4'd7;  // denominator <= a + b, exact
    localparam logic [3:0] OP_DIVST = 4'd8;  // start divide, or zero gain and jump
    localparam logic [3:0] OP_DIVWT = 4'd9;  // hold until divide done, dst <= quotient
    localparam logic [3:0] OP_OUT   = 4'd10; // load output register, jump

    // operand sources
    localparam logic [3:0] SRC_ZERO = 4'd0;
    localparam logic [3:0] SRC_A    = 4'd1;
    localparam logic [3:0] SRC_H    = 4'd2;
    localparam logic [3:0] SRC_Q    = 4'd3;
    localparam logic [3:0] SRC_R    = 4'd4;
    localparam logic [3:0] SRC_X    = 4'd5;
    localparam logic [3:0] SRC_P    = 4'd6;
    localparam logic [3:0] SRC_XP   = 4'd7;
    localparam logic [3:0] SRC_PP   = 4'd8;
    localparam logic [3:0] SRC_T    = 4'd9;
    localparam logic [3:0] SRC_HP   = 4'd10;
    localparam logic [3:0] SRC_K    = 4'd11;
    localparam logic [3:0] SRC_Z    = 4'd12;

    // destinations
    localparam logic [2:0] DST_NONE = 3'd0;
    localparam logic [2:0] DST_X    = 3'd1;
    localparam logic [2:0] DST_P    = 3'd2;
    localparam logic [2:0] DST_XP   = 3'd3;
    localparam logic [2:0] DST_PP   = 3'd4;
    localparam logic [2:0] DST_T    = 3'd5;
    localparam logic [2:0] DST_HP   = 3'd6;
    localparam logic [2:0] DST_K    = 3'd7;

    // program addresses referenced by the sequencer
    localparam logic [STEP_W-1:0] STEP_IDLE  = 5'd0;
    localparam logic [STEP_W-1:0] STEP_FIRST = 5'd1;
    localparam logic [STEP_W-1:0] STEP_DIVWT = 5'd14;
    localparam logic [STEP_W-1:0] STEP_POST  = 5'd15;
    localparam logic [STEP_W-1:0] STEP_OUT   = 5'd26;

    typedef struct packed {
        logic [3:0]        op;
        logic [3:0]        sa;
        logic [3:0]        sb;
        logic [2:0]        dst;
        logic [STEP_W-1:0] tgt;
    } ctrl_t;

    function automatic ctrl_t mk(input logic [3:0] op, input logic [3:0] sa,
                                 input logic [3:0] sb, input logic [2:0] dst,
                                 input logic [STEP_W-1:0] tgt);
        ctrl_t c;
        c.op  = op;
        c.sa  = sa;
        c.sb  = sb;
        c.dst = dst;
        c.tgt = tgt;
        return c;
    endfunction

    // control program: predict, gain, update
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t c;
        case (step)
            5'd0:  c = mk(OP_IDLE,  SRC_ZERO, SRC_ZERO, DST_NONE, STEP_IDLE);
            5'd1:  c = mk(OP_MUL,   SRC_A,    SRC_X,    DST_NONE, STEP_IDLE);
            5'd2:  c = mk(OP_RND,   SRC_ZERO, SRC_ZERO, DST_XP,   STEP_IDLE);
            5'd3:  c = mk(OP_MUL,   SRC_A,    SRC_P,    DST_NONE, STEP_IDLE);
            5'd4:  c = mk(OP_RND,   SRC_ZERO, SRC_ZERO, DST_T,    STEP_IDLE);
            5'd5:  c = mk(OP_MUL,   SRC_T,    SRC_A,    DST_NONE, STEP_IDLE);
            5'd6:  c = mk(OP_RND,   SRC_ZERO, SRC_ZERO, DST_T,    STEP_IDLE);
            5'd7:  c = mk(OP_ADDC,  SRC_T,    SRC_Q,    DST_PP,   STEP_IDLE);
            5'd8:  c = mk(OP_MUL,   SRC_PP,   SRC_H,    DST_NONE, STEP_IDLE);
            5'd9:  c = mk(OP_RND,   SRC_ZERO, SRC_ZERO, DST_HP,   STEP_IDLE);
            5'd10: c = mk(OP_MUL,   SRC_HP,   SRC_H,    DST_NONE, STEP_IDLE);
            5'd11: c = mk(OP_RND,   SRC_ZERO, SRC_ZERO, DST_T,    STEP_IDLE);
            5'd12: c = mk(OP_DEN,   SRC_T,    SRC_R,    DST_NONE, STEP_IDLE);
            5'd13: c = mk(OP_DIVST, SRC_ZERO, SRC_ZERO, DST_K,    STEP_POST);
            5'd14: c = mk(OP_DIVWT, SRC_ZERO, SRC_ZERO, DST_K,    STEP_IDLE);
            5'd15: c = mk(OP_MUL,   SRC_H,    SRC_XP,   DST_NONE, STEP_IDLE);
            5'd16: c = mk(OP_RND,   SRC_ZERO, SRC_ZERO, DST_T,    STEP_IDLE);
            5'd17: c = mk(OP_SUBS,  SRC_Z,    SRC_T,    DST_T,    STEP_IDLE);
            5'd18: c = mk(OP_MUL,   SRC_K,    SRC_T,    DST_NONE, STEP_IDLE);
            5'd19: c = mk(OP_RND,   SRC_ZERO, SRC_ZERO, DST_T,    STEP_IDLE);
            5'd20: c = mk(OP_ADDS,  SRC_XP,   SRC_T,    DST_X,    STEP_IDLE);
            5'd21: c = mk(OP_MUL,   SRC_K,    SRC_H,    DST_NONE, STEP_IDLE);
            5'd22: c = mk(OP_RND,   SRC_ZERO, SRC_ZERO, DST_T,    STEP_IDLE);
            5'd23: c = mk(OP_MUL,   SRC_T,    SRC_PP,   DST_NONE, STEP_IDLE);
            5'd24: c = mk(OP_RND,   SRC_ZERO, SRC_ZERO, DST_T,    STEP_IDLE);
            5'd25: c = mk(OP_SUBC,  SRC_PP,   SRC_T,    DST_P,    STEP_IDLE);
            5'd26: c = mk(OP_OUT,   SRC_ZERO, SRC_ZERO, DST_NONE, STEP_IDLE);
            default: c = mk(OP_IDLE, SRC_ZERO, SRC_ZERO, DST_NONE, STEP_IDLE);
        endcase
        return c;
    endfunction

    // saturate a 48-bit signed value to Q16.16 range
    function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'(Q_MAX))
            r = Q_MAX;
        else if (v < 48'(Q_MIN))
            r = Q_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    // saturate a 34-bit signed sum, optionally clamping below at zero
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v,
                                                 input logic clamp_zero);
        logic signed [31:0] r;
        if (clamp_zero && v[33])
            r = '0;
        else if (v > 34'(Q_MAX))
            r = Q_MAX;
        else if (v < 34'(Q_MIN))
            r = Q_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

@@ src/skf_div.sv @@
// rounded Q16.16 divider for the kalman gain, two quotient bits per cycle
// computes sat(round(num * 2^16 / den)) for den > 0, ties away from zero
// depends on skf_pkg
module skf_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic [31:0]        den,
    output logic               busy,
    output logic signed [31:0] quo
);

    logic        busy_reg;
    logic [3:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] sh_reg;
    logic [31:0] den_reg;
    logic        neg_reg;
    logic        ovf_reg;

    logic [31:0] mag;
    logic [47:0] dividend;
    logic [32:0] t1;
    logic [32:0] t2;
    logic        ge1;
    logic        ge2;
    logic [31:0] r1;
    logic [31:0] r2;
    logic [31:0] sh1;
    logic [31:0] sh2;
    logic [31:0] qv;

    // magnitude of the numerator, shifted, plus half the divisor for rounding
    always_comb
    begin
        mag      = num[31] ? (~num + 32'd1) : num;
        dividend = {mag, 16'h0000} + {17'h0, den[31:1]};
    end

    // two restoring steps; the remainder stays below the divisor unless the quotient overflows
    always_comb
    begin
        t1  = {rem_reg, sh_reg[31]};
        ge1 = t1 >= {1'b0, den_reg};
        r1  = ge1 ? 32'(t1 - {1'b0, den_reg}) : t1[31:0];
        sh1 = {sh_reg[30:0], ge1};
        t2  = {r1, sh1[31]};
        ge2 = t2 >= {1'b0, den_reg};
        r2  = ge2 ? 32'(t2 - {1'b0, den_reg}) : t2[31:0];
        sh2 = {sh1[30:0], ge2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 4'd1;
            if (cnt_reg == 4'hF)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {16'h0000, dividend[47:32]};
            sh_reg  <= dividend[31:0];
            den_reg <= den;
            neg_reg <= num[31];
            // quotient of 2^32 or more
            ovf_reg <= {16'h0000, dividend[47:32]} >= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= r2;
            sh_reg  <= sh2;
        end
    end

    always_comb
    begin
        qv = (ovf_reg || sh_reg > skf_pkg::Q_ONE_OVF) ? skf_pkg::Q_ONE_OVF : sh_reg;
        if (neg_reg)
            quo = ~qv + 32'd1;
        else if (qv == skf_pkg::Q_ONE_OVF)
            quo = skf_pkg::Q_MAX;
        else
            quo = qv;
    end

    assign busy = busy_reg;

endmodule

@@ src/scalar_kalman_filter_unit.sv @@
// scalar kalman filter: microcoded Q16.16 sequencer, multiplier and registers
// depends on skf_pkg and skf_div
//
// usage:
//   s_axis carries one measurement per transfer (signed Q16.16).
//   m_axis carries one result per measurement: estimate, covariance, gain.
//   cfg_we/cfg_addr/cfg_data write the six filter registers; write only
//   while no measurement is in flight.
// timing:
//   a measurement is taken only while the sequencer is idle, so the next
//   measurement waits until the program has finished the last one. the
//   divide is skipped when the gain denominator is not positive. the
//   divider resolves two quotient bits per cycle and the single 32x32
//   multiplier needs two steps per product.
// reset:
//   registers return to their defaults and the first measurement after
//   reset starts from the initial estimate and covariance.
// stall:
//   the result sits in an output register; the next measurement is taken
//   and processed meanwhile, and the sequencer holds on its output step
//   only if the previous result has still not been transferred.
module scalar_kalman_filter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] measurement
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // [31:0] estimate, [62:32] covariance,
                                        // [94:63] gain, [95] zero
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_data
);

    // configuration
    logic [31:0] a_reg;
    logic [30:0] q_reg;
    logic [31:0] h_reg;
    logic [30:0] r_reg;
    logic [31:0] x0_reg;
    logic [30:0] p0_reg;

    // sequencer
    logic [skf_pkg::STEP_W-1:0] step_reg;
    logic [skf_pkg::STEP_W-1:0] step_next;
    skf_pkg::ctrl_t             ctl;
    logic                       started_reg;

    // datapath
    logic signed [31:0] x_reg;
    logic signed [31:0] p_reg;
    logic signed [31:0] xp_reg;
    logic signed [31:0] pp_reg;
    logic signed [31:0] t_reg;
    logic signed [31:0] hp_reg;
    logic signed [31:0] k_reg;
    logic signed [31:0] z_reg;
    logic signed [32:0] den_reg;
    logic signed [63:0] prod_reg;

    // output register
    logic        out_valid_reg;
    logic [31:0] est_out_reg;
    logic [30:0] cov_out_reg;
    logic [31:0] gain_out_reg;

    logic signed [31:0] opa;
    logic signed [31:0] opb;
    logic signed [63:0] biased;
    logic signed [31:0] rnd_val;
    logic signed [33:0] sum;
    logic signed [31:0] alu_val;
    logic signed [31:0] wr_val;
    logic               wr_en;
    logic               in_xfer;
    logic               out_free;
    logic               den_pos;
    logic               div_start;
    logic               div_busy;
    logic signed [31:0] div_quo;

    assign ctl       = skf_pkg::ucode(step_reg);
    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign den_pos   = !den_reg[32] && (den_reg != 33'sd0);
    assign div_start = (ctl.op == skf_pkg::OP_DIVST) && den_pos;

    assign s_axis_tready = (step_reg == skf_pkg::STEP_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, gain_out_reg, cov_out_reg, est_out_reg};

    function automatic logic signed [31:0] pick(input logic [3:0] sel,
            input logic [31:0] a, input logic [30:0] q, input logic [31:0] h,
            input logic [30:0] r, input logic [31:0] x, input logic [31:0] p,
            input logic [31:0] xp, input logic [31:0] pp, input logic [31:0] t,
            input logic [31:0] hp, input logic [31:0] k, input logic [31:0] z);
        logic [31:0] v;
        case (sel)
            skf_pkg::SRC_A:  v = a;
            skf_pkg::SRC_H:  v = h;
            skf_pkg::SRC_Q:  v = {1'b0, q};
            skf_pkg::SRC_R:  v = {1'b0, r};
            skf_pkg::SRC_X:  v = x;
            skf_pkg::SRC_P:  v = p;
            skf_pkg::SRC_XP: v = xp;
            skf_pkg::SRC_PP: v = pp;
            skf_pkg::SRC_T:  v = t;
            skf_pkg::SRC_HP: v = hp;
            skf_pkg::SRC_K:  v = k;
            skf_pkg::SRC_Z:  v = z;
            default:         v = '0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        opa = pick(ctl.sa, a_reg, q_reg, h_reg, r_reg, x_reg, p_reg, xp_reg, pp_reg,
                   t_reg, hp_reg, k_reg, z_reg);
        opb = pick(ctl.sb, a_reg, q_reg, h_reg, r_reg, x_reg, p_reg, xp_reg, pp_reg,
                   t_reg, hp_reg, k_reg, z_reg);
    end

    // round to nearest, ties away from zero: bias differs by sign
    always_comb
    begin
        biased  = prod_reg + (prod_reg[63] ? 64'sd32767 : 64'sd32768);
        rnd_val = skf_pkg::sat48(biased[63:16]);
    end

    always_comb
    begin
        if (ctl.op inside {skf_pkg::OP_SUBS, skf_pkg::OP_SUBC})
            sum = 34'(opa) - 34'(opb);
        else
            sum = 34'(opa) + 34'(opb);
        alu_val = skf_pkg::sat34(sum, ctl.op inside {skf_pkg::OP_ADDC, skf_pkg::OP_SUBC});
    end

    always_comb
    begin
        wr_en  = 1'b0;
        wr_val = alu_val;
        case (ctl.op)
            skf_pkg::OP_RND:
            begin
                wr_en  = 1'b1;
                wr_val = rnd_val;
            end
            skf_pkg::OP_ADDS, skf_pkg::OP_SUBS, skf_pkg::OP_ADDC, skf_pkg::OP_SUBC:
            begin
                wr_en = 1'b1;
            end
            skf_pkg::OP_DIVST:
            begin
                // zero gain when the denominator is not positive
                wr_en  = !den_pos;
                wr_val = '0;
            end
            skf_pkg::OP_DIVWT:
            begin
                wr_en  = !div_busy;
                wr_val = div_quo;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        step_next = step_reg + 5'd1;
        case (ctl.op)
            skf_pkg::OP_IDLE:
            begin
                if (!in_xfer)
                    step_next = step_reg;
            end
            skf_pkg::OP_DIVST:
            begin
                if (!den_pos)
                    step_next = ctl.tgt;
            end
            skf_pkg::OP_DIVWT:
            begin
                if (div_busy)
                    step_next = step_reg;
            end
            skf_pkg::OP_OUT:
            begin
                step_next = out_free ? ctl.tgt : step_reg;
            end
            default:
            begin
                step_next = step_reg + 5'd1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= skf_pkg::STEP_IDLE;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            a_reg         <= skf_pkg::RST_STATE_GAIN;
            q_reg         <= skf_pkg::RST_PROCESS_NOISE;
            h_reg         <= skf_pkg::RST_OBS_GAIN;
            r_reg         <= skf_pkg::RST_MEAS_NOISE;
            x0_reg        <= skf_pkg::RST_INIT_ESTIMATE;
            p0_reg        <= skf_pkg::RST_INIT_COVARIANCE;
        end
        else
        begin
            step_reg <= step_next;
            if (in_xfer)
                started_reg <= 1'b1;
            if (ctl.op == skf_pkg::OP_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_addr)
                    skf_pkg::REG_STATE_GAIN:      a_reg  <= cfg_data;
                    skf_pkg::REG_PROCESS_NOISE:   q_reg  <= cfg_data[30:0];
                    skf_pkg::REG_OBS_GAIN:        h_reg  <= cfg_data;
                    skf_pkg::REG_MEAS_NOISE:      r_reg  <= cfg_data[30:0];
                    skf_pkg::REG_INIT_ESTIMATE:   x0_reg <= cfg_data;
                    skf_pkg::REG_INIT_COVARIANCE: p0_reg <= cfg_data[30:0];
                    default:                      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            z_reg <= s_axis_tdata;
            if (!started_reg)
            begin
                x_reg <= x0_reg;
                p_reg <= {1'b0, p0_reg};
            end
        end
        if (ctl.op == skf_pkg::OP_MUL)
            prod_reg <= opa * opb;
        if (ctl.op == skf_pkg::OP_DEN)
            den_reg <= 33'(opa) + 33'(opb);
        if (wr_en)
        begin
            case (ctl.dst)
                skf_pkg::DST_X:  x_reg  <= wr_val;
                skf_pkg::DST_P:  p_reg  <= wr_val;
                skf_pkg::DST_XP: xp_reg <= wr_val;
                skf_pkg::DST_PP: pp_reg <= wr_val;
                skf_pkg::DST_T:  t_reg  <= wr_val;
                skf_pkg::DST_HP: hp_reg <= wr_val;
                skf_pkg::DST_K:  k_reg  <= wr_val;
                default:         ;
            endcase
        end
        if (ctl.op == skf_pkg::OP_OUT && out_free)
        begin
            est_out_reg  <= x_reg;
            cov_out_reg  <= p_reg[30:0];
            gain_out_reg <= k_reg;
        end
    end

    skf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (hp_reg),
        .den   (den_reg[31:0]),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> step_reg == skf_pkg::STEP_DIVWT)
        else $error("divider busy outside its wait step");

    a_start_prog: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> step_reg == skf_pkg::STEP_FIRST)
        else $error("program did not start after input transfer");

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(step_reg) == skf_pkg::STEP_OUT)
        else $error("result raised outside the output step");

endmodule

@@ tb/tb_scalar_kalman_filter_unit.sv @@
`timescale 1ns / 1ps
// testbench for scalar_kalman_filter_unit: directed and random measurement streams
// checked against a bit-exact Q16.16 kalman predictor kept inside the bench
// depends on skf_pkg and the scalar_kalman_filter_unit rtl
module tb_scalar_kalman_filter_unit;

    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_PERCENT = 37;
    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] estimate;
        logic [30:0] covariance;
        logic [31:0] gain;
    } kf_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] measurement
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;   // [31:0] estimate, [62:32] covariance, [94:63] gain
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_data;

    // filter registers as the bench believes them
    logic signed [31:0] fc_state_gain;
    logic        [30:0] fc_process_noise;
    logic signed [31:0] fc_obs_gain;
    logic        [30:0] fc_meas_noise;
    logic signed [31:0] fc_init_estimate;
    logic        [30:0] fc_init_covariance;

    // filter state
    longint filt_estimate;
    longint filt_covariance;
    bit     filt_started;

    kf_result_t pending_results[$];
    int         mismatch_count;
    bit         no_gaps;
    bit         rx_hold;
    event       hold_trigger;

    scalar_kalman_filter_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic longint sat_q(input longint v);
        longint r;
        r = v;
        if (v > QMAX)
            r = QMAX;
        else if (v < QMIN)
            r = QMIN;
        return r;
    endfunction

    function automatic longint clamp_cov(input longint v);
        longint r;
        r = v;
        if (v < 0)
            r = 0;
        else if (v > QMAX)
            r = QMAX;
        return r;
    endfunction

    // rounded Q16.16 product, ties away from zero
    function automatic longint q_mul(input longint u, input longint v);
        longint prod;
        longint mag;
        bit     neg;
        prod = u * v;
        neg  = prod < 0;
        mag  = neg ? -prod : prod;
        mag  = (mag + 32768) >> 16;
        return sat_q(neg ? -mag : mag);
    endfunction

    // rounded Q16.16 quotient, den > 0
    function automatic longint q_div(input longint num, input longint den);
        longint mag;
        longint quo;
        bit     neg;
        neg = num < 0;
        mag = neg ? -num : num;
        quo = ((mag << 16) + den / 2) / den;
        if (quo > 64'sd2147483648)
            quo = 64'sd2147483648;
        return sat_q(neg ? -quo : quo);
    endfunction

    function automatic kf_result_t kalman_step(input logic [31:0] z_bits);
        longint a, h, q, r, z, x, p;
        longint xp, pp, hp, den, k, innov, xn, pn;
        kf_result_t res;
        a = longint'(fc_state_gain);
        h = longint'(fc_obs_gain);
        q = longint'(fc_process_noise);
        r = longint'(fc_meas_noise);
        z = longint'($signed(z_bits));
        if (filt_started)
        begin
            x = filt_estimate;
            p = filt_covariance;
        end
        else
        begin
            x = longint'(fc_init_estimate);
            p = longint'(fc_init_covariance);
        end
        xp  = q_mul(a, x);
        pp  = clamp_cov(q_mul(q_mul(a, p), a) + q);
        hp  = q_mul(pp, h);
        den = q_mul(hp, h) + r;
        k   = (den > 0) ? q_div(hp, den) : 0;
        innov = sat_q(z - q_mul(h, xp));
        xn  = sat_q(xp + q_mul(k, innov));
        pn  = clamp_cov(pp - q_mul(q_mul(k, h), pp));
        filt_estimate   = xn;
        filt_covariance = pn;
        filt_started    = 1'b1;
        res.estimate   = xn[31:0];
        res.covariance = pn[30:0];
        res.gain       = k[31:0];
        return res;
    endfunction

    task automatic flag_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t: %s expected %h, got %h", $time, field, want, got);
    endtask

    // result checker
    always @(posedge clk)
    begin : check_results
        kf_result_t want;
        kf_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.estimate   = m_axis_tdata[31:0];
            got.covariance = m_axis_tdata[62:32];
            got.gain       = m_axis_tdata[94:63];
            if (pending_results.size() == 0)
            begin
                flag_mismatch("unexpected result, estimate", 32'h0, got.estimate);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.estimate !== want.estimate)
                    flag_mismatch("estimate", want.estimate, got.estimate);
                if (got.covariance !== want.covariance)
                    flag_mismatch("covariance", {1'b0, want.covariance},
                                  {1'b0, got.covariance});
                if (got.gain !== want.gain)
                    flag_mismatch("gain", want.gain, got.gain);
            end
        end
    end

    // result side ready, with random idling and a long hold on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold)
                m_axis_tready <= 1'b0;
            else if (no_gaps)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    initial
    begin
        rx_hold = 1'b0;
        forever
        begin
            @(hold_trigger);
            rx_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold = 1'b0;
        end
    end

    task automatic send_measurement(input logic [31:0] z);
        @(negedge clk);
        while (!no_gaps && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= z;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(kalman_step(z));
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        case (idx)
            skf_pkg::REG_STATE_GAIN:      fc_state_gain      = value;
            skf_pkg::REG_PROCESS_NOISE:   fc_process_noise   = value[30:0];
            skf_pkg::REG_OBS_GAIN:        fc_obs_gain        = value;
            skf_pkg::REG_MEAS_NOISE:      fc_meas_noise      = value[30:0];
            skf_pkg::REG_INIT_ESTIMATE:   fc_init_estimate   = value;
            skf_pkg::REG_INIT_COVARIANCE: fc_init_covariance = value[30:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_reg_value(input logic [2:0] idx);
        logic [31:0] v;
        int mode;
        mode = $urandom_range(0, 3);
        if (mode == 0)
        begin
            case ($urandom_range(0, 3))
                0:       v = 32'h0000_0000;
                1:       v = 32'h7FFF_FFFF;
                2:       v = 32'h8000_0000;
                default: v = 32'hFFFF_FFFF;
            endcase
        end
        else if (mode == 3)
        begin
            v = $urandom;
        end
        else
        begin
            case (idx)
                skf_pkg::REG_STATE_GAIN:
                begin
                    v = 32'h0001_0000 + $urandom_range(0, 32'h8000) - 32'h4000;
                end
                skf_pkg::REG_OBS_GAIN:
                begin
                    v = 32'h0001_0000 + $urandom_range(0, 32'h1_0000) - 32'h8000;
                    if ($urandom_range(0, 3) == 0)
                        v = -v;
                end
                skf_pkg::REG_PROCESS_NOISE: v = $urandom_range(0, 32'h4000);
                skf_pkg::REG_MEAS_NOISE:    v = $urandom_range(1, 32'h0008_0000);
                default:                    v = $urandom_range(0, 32'h0100_0000);
            endcase
        end
        return v;
    endfunction

    function automatic logic [31:0] pick_measurement();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1: v = $urandom;
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            // noisy samples around 14.0
            default: v = 32'h000E_0000 + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
        return v;
    endfunction

    // first items run from the reset settings of a, q, h and r
    task automatic test_defaults();
        write_reg(skf_pkg::REG_INIT_ESTIMATE, 32'hFFFC_C000);     // -3.25
        write_reg(skf_pkg::REG_INIT_COVARIANCE, 32'h8003_0000);   // top bit dropped, 3.0
        send_measurement(32'h0000_0000);
        send_measurement(32'h7FFF_FFFF);
        send_measurement(32'h8000_0000);
        send_measurement(32'h0000_0001);
        send_measurement(32'hFFFF_FFFF);
        wait_drained();
    endtask

    task automatic test_zero_denominator();
        write_reg(skf_pkg::REG_OBS_GAIN, 32'h0000_0000);
        write_reg(skf_pkg::REG_MEAS_NOISE, 32'h0000_0000);
        write_reg(skf_pkg::REG_PROCESS_NOISE, 32'h0000_0100);
        send_measurement(32'h000E_0000);
        send_measurement(32'hFFF2_0000);
        send_measurement(32'h7FFF_FFFF);
        wait_drained();
    endtask

    task automatic test_saturation();
        write_reg(skf_pkg::REG_STATE_GAIN, 32'h7FFF_FFFF);
        write_reg(skf_pkg::REG_PROCESS_NOISE, 32'hFFFF_FFFF);
        write_reg(skf_pkg::REG_OBS_GAIN, 32'h8000_0000);
        write_reg(skf_pkg::REG_MEAS_NOISE, 32'h0000_0000);
        send_measurement(32'h7FFF_FFFF);
        send_measurement(32'h8000_0000);
        send_measurement(32'h0000_0000);
        send_measurement(32'h0000_0001);
        wait_drained();
        write_reg(skf_pkg::REG_STATE_GAIN, 32'h8000_0000);
        write_reg(skf_pkg::REG_PROCESS_NOISE, 32'h0000_0000);
        write_reg(skf_pkg::REG_OBS_GAIN, 32'h7FFF_FFFF);
        write_reg(skf_pkg::REG_MEAS_NOISE, 32'hFFFF_FFFF);
        send_measurement(32'h8000_0000);
        send_measurement(32'h7FFF_FFFF);
        send_measurement(32'h5555_5555);
        send_measurement(32'hAAAA_AAAA);
        wait_drained();
    endtask

    // writes to spare indexes and to the initial values once started change nothing
    task automatic test_ignored_writes();
        write_reg(skf_pkg::REG_STATE_GAIN, 32'h0001_0000);
        write_reg(skf_pkg::REG_OBS_GAIN, 32'h0001_0000);
        write_reg(skf_pkg::REG_MEAS_NOISE, 32'h0004_0000);
        write_reg(skf_pkg::REG_INIT_ESTIMATE, 32'h7FFF_FFFF);
        write_reg(skf_pkg::REG_INIT_COVARIANCE, 32'h7FFF_FFFF);
        write_reg(REG_SPARE_6, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_7, 32'hFFFF_FFFF);
        send_measurement(32'h000E_0000);
        send_measurement(32'h000D_8000);
        wait_drained();
    endtask

    // hold the result side long enough that the input stalls
    task automatic test_backpressure();
        -> hold_trigger;
        repeat (6) send_measurement(pick_measurement());
        wait_drained();
    endtask

    task automatic test_random_runs();
        for (int run = 0; run < 8; run++)
        begin
            for (int idx = 0; idx < 8; idx++)
                if (idx < 6 || $urandom_range(0, 1) == 1)
                    write_reg(3'(idx), pick_reg_value(3'(idx)));
            no_gaps = (run == 3);
            for (int n = 0; n < 50; n++)
            begin
                if (run == 5 && n == 10)
                    -> hold_trigger;
                if (run == 6 && n == 25)
                    wait_drained();
                send_measurement(pick_measurement());
            end
            wait_drained();
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        rst_n              = 1'b0;
        s_axis_tvalid      = 1'b0;
        s_axis_tdata       = '0;
        cfg_we             = 1'b0;
        cfg_addr           = '0;
        cfg_data           = '0;
        no_gaps            = 1'b0;
        mismatch_count     = 0;
        fc_state_gain      = skf_pkg::RST_STATE_GAIN;
        fc_process_noise   = skf_pkg::RST_PROCESS_NOISE;
        fc_obs_gain        = skf_pkg::RST_OBS_GAIN;
        fc_meas_noise      = skf_pkg::RST_MEAS_NOISE;
        fc_init_estimate   = skf_pkg::RST_INIT_ESTIMATE;
        fc_init_covariance = skf_pkg::RST_INIT_COVARIANCE;
        filt_estimate      = 0;
        filt_covariance    = 0;
        filt_started       = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_defaults();
        test_zero_denominator();
        test_saturation();
        test_ignored_writes();
        test_backpressure();
        test_random_runs();

        wait_drained();
        repeat (60) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
